/* sv/two_key_led_animation_controller_macros.svh */
// Assertion macros shared by the LED animation controller.
`ifndef TWO_KEY_LED_ANIMATION_CONTROLLER_MACROS_SVH
`define TWO_KEY_LED_ANIMATION_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLAC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

/* sv/tlac_pkg.sv */
// Types, constants and the sine table of the LED animation controller.
`timescale 1ns / 1ps

package tlac_pkg;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_STEADY = 2'd1,
		MODE_BREATH = 2'd2,
		MODE_TAIL   = 2'd3
	} anim_mode_t;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_DOWN = 2'd1,
		EV_UP   = 2'd2
	} key_event_t;

	localparam logic [2:0] REG_LED0_RED   = 3'd0;
	localparam logic [2:0] REG_LED0_GREEN = 3'd1;
	localparam logic [2:0] REG_LED0_BLUE  = 3'd2;
	localparam logic [2:0] REG_LED1_RED   = 3'd3;
	localparam logic [2:0] REG_LED1_GREEN = 3'd4;
	localparam logic [2:0] REG_LED1_BLUE  = 3'd5;

	localparam logic [7:0] RESET_RED   = 8'd1;
	localparam logic [7:0] RESET_GREEN = 8'd135;
	localparam logic [7:0] RESET_BLUE  = 8'd255;

	localparam logic [8:0] DECAY_LOAD   = 9'(64 << 2);
	localparam logic [4:0] STEADY_LEVEL = 5'd8;
	localparam logic [6:0] TAIL_MAX     = 7'd64;
	localparam logic [7:0] TAIL_BASE    = 8'd192;

	typedef struct packed {
		logic [7:0] led0_red;
		logic [7:0] led0_green;
		logic [7:0] led0_blue;
		logic [7:0] led1_red;
		logic [7:0] led1_green;
		logic [7:0] led1_blue;
	} colour_set_t;

	typedef struct packed {
		anim_mode_t mode;
		logic [8:0] decay0;
		logic [8:0] decay1;
		logic       k0_was;
		logic       k1_was;
		logic       km_was;
	} frame_state_t;

	typedef struct packed {
		logic [4:0] led0_brightness;
		logic [7:0] led0_red;
		logic [7:0] led0_green;
		logic [7:0] led0_blue;
		logic [4:0] led1_brightness;
		logic [7:0] led1_red;
		logic [7:0] led1_green;
		logic [7:0] led1_blue;
		key_event_t key0_event;
		key_event_t key1_event;
	} result_t;

	localparam logic [7:0] WAVE [256] = '{
		8'h80, 8'h83, 8'h86, 8'h89, 8'h8C, 8'h90, 8'h93, 8'h96,
		8'h99, 8'h9C, 8'h9F, 8'hA2, 8'hA5, 8'hA8, 8'hAB, 8'hAE,
		8'hB1, 8'hB3, 8'hB6, 8'hB9, 8'hBC, 8'hBF, 8'hC1, 8'hC4,
		8'hC7, 8'hC9, 8'hCC, 8'hCE, 8'hD1, 8'hD3, 8'hD5, 8'hD8,
		8'hDA, 8'hDC, 8'hDE, 8'hE0, 8'hE2, 8'hE4, 8'hE6, 8'hE8,
		8'hEA, 8'hEB, 8'hED, 8'hEF, 8'hF0, 8'hF1, 8'hF3, 8'hF4,
		8'hF5, 8'hF6, 8'hF8, 8'hF9, 8'hFA, 8'hFA, 8'hFB, 8'hFC,
		8'hFD, 8'hFD, 8'hFE, 8'hFE, 8'hFE, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hFE, 8'hFE, 8'hFD,
		8'hFD, 8'hFC, 8'hFB, 8'hFA, 8'hFA, 8'hF9, 8'hF8, 8'hF6,
		8'hF5, 8'hF4, 8'hF3, 8'hF1, 8'hF0, 8'hEF, 8'hED, 8'hEB,
		8'hEA, 8'hE8, 8'hE6, 8'hE4, 8'hE2, 8'hE0, 8'hDE, 8'hDC,
		8'hDA, 8'hD8, 8'hD5, 8'hD3, 8'hD1, 8'hCE, 8'hCC, 8'hC9,
		8'hC7, 8'hC4, 8'hC1, 8'hBF, 8'hBC, 8'hB9, 8'hB6, 8'hB3,
		8'hB1, 8'hAE, 8'hAB, 8'hA8, 8'hA5, 8'hA2, 8'h9F, 8'h9C,
		8'h99, 8'h96, 8'h93, 8'h90, 8'h8C, 8'h89, 8'h86, 8'h83,
		8'h80, 8'h7D, 8'h7A, 8'h77, 8'h74, 8'h70, 8'h6D, 8'h6A,
		8'h67, 8'h64, 8'h61, 8'h5E, 8'h5B, 8'h58, 8'h55, 8'h52,
		8'h4F, 8'h4D, 8'h4A, 8'h47, 8'h44, 8'h41, 8'h3F, 8'h3C,
		8'h39, 8'h37, 8'h34, 8'h32, 8'h2F, 8'h2D, 8'h2B, 8'h28,
		8'h26, 8'h24, 8'h22, 8'h20, 8'h1E, 8'h1C, 8'h1A, 8'h18,
		8'h16, 8'h15, 8'h13, 8'h11, 8'h10, 8'h0F, 8'h0D, 8'h0C,
		8'h0B, 8'h0A, 8'h08, 8'h07, 8'h06, 8'h06, 8'h05, 8'h04,
		8'h03, 8'h03, 8'h02, 8'h02, 8'h02, 8'h01, 8'h01, 8'h01,
		8'h01, 8'h01, 8'h01, 8'h01, 8'h02, 8'h02, 8'h02, 8'h03,
		8'h03, 8'h04, 8'h05, 8'h06, 8'h06, 8'h07, 8'h08, 8'h0A,
		8'h0B, 8'h0C, 8'h0D, 8'h0F, 8'h10, 8'h11, 8'h13, 8'h15,
		8'h16, 8'h18, 8'h1A, 8'h1C, 8'h1E, 8'h20, 8'h22, 8'h24,
		8'h26, 8'h28, 8'h2B, 8'h2D, 8'h2F, 8'h32, 8'h34, 8'h37,
		8'h39, 8'h3C, 8'h3F, 8'h41, 8'h44, 8'h47, 8'h4A, 8'h4D,
		8'h4F, 8'h52, 8'h55, 8'h58, 8'h5B, 8'h5E, 8'h61, 8'h64,
		8'h67, 8'h6A, 8'h6D, 8'h70, 8'h74, 8'h77, 8'h7A, 8'h7D
	};

	// Table index of the decaying tail: 128 + (64 - min(count / 4, 64)).
	function automatic logic [7:0] tail_index(input logic [8:0] count);
		logic [6:0] c;
		c = count[8:2];
		if (c > TAIL_MAX) begin
			c = TAIL_MAX;
		end
		return TAIL_BASE - {1'b0, c};
	endfunction

endpackage

/* sv/two_key_led_animation_controller.sv */
// A frame tick's result is loaded into the result register at the edge that accepts the tick.
// Throughput: one tick per cycle while the output is taken; the single result register is refilled as it drains.
// Input is held off only while the result register is full and not being taken.
// Reset (arst_n low, asynchronous): colours return to 1/135/255, mode to steady,
// decay counters and button history to zero, and the result register empties.
`timescale 1ns / 1ps
`include "two_key_led_animation_controller_macros.svh"

module two_key_led_animation_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] frame_number,
	input  logic        key0_level,
	input  logic        key1_level,
	input  logic        mode_key_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  led0_brightness,
	output logic [7:0]  led0_out_red,
	output logic [7:0]  led0_out_green,
	output logic [7:0]  led0_out_blue,
	output logic [4:0]  led1_brightness,
	output logic [7:0]  led1_out_red,
	output logic [7:0]  led1_out_green,
	output logic [7:0]  led1_out_blue,
	output logic [1:0]  key0_event,
	output logic [1:0]  key1_event
);
	import tlac_pkg::*;

	colour_set_t  colours;
	result_t      result_d;
	result_t      result_q;
	frame_state_t st;
	logic         accept;
	logic         mode_press;
	logic         leds_dark;
	logic         leds_blank;
	logic         ev_legal;

	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	tlac_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.colours   (colours)
	);

	tlac_frame_logic u_frame (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.frame_number   (frame_number),
		.key0_level     (key0_level),
		.key1_level     (key1_level),
		.mode_key_level (mode_key_level),
		.colours        (colours),
		.result         (result_d),
		.state          (st)
	);

	tlac_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.d         (result_d),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.q         (result_q)
	);

	assign led0_brightness = result_q.led0_brightness;
	assign led0_out_red    = result_q.led0_red;
	assign led0_out_green  = result_q.led0_green;
	assign led0_out_blue   = result_q.led0_blue;
	assign led1_brightness = result_q.led1_brightness;
	assign led1_out_red    = result_q.led1_red;
	assign led1_out_green  = result_q.led1_green;
	assign led1_out_blue   = result_q.led1_blue;
	assign key0_event      = result_q.key0_event;
	assign key1_event      = result_q.key1_event;

	assign mode_press = accept && !mode_key_level && !st.km_was;
	assign leds_dark  = led0_brightness == 5'd0 && led1_brightness == 5'd0;
	assign leds_blank = leds_dark && led0_out_red == 8'd0 && led1_out_blue == 8'd0;
	assign ev_legal   = key0_event <= EV_UP && key1_event <= EV_UP;

	`TLAC_ASSERT_IMPL(a_stall_blocks_input, clk, arst_n, out_valid && !out_ready, !in_ready)
	`TLAC_ASSERT_NEXT(a_mode_press_blanks, clk, arst_n, mode_press, out_valid && leds_blank)
	`TLAC_ASSERT_NEXT(a_off_mode_dark, clk, arst_n, accept && st.mode == MODE_OFF, leds_dark)
	`TLAC_ASSERT_IMPL(a_event_code_legal, clk, arst_n, out_valid, ev_legal)

endmodule

/* sv/tlac_cfg_regs.sv */
// Colour configuration registers of both LEDs.
`timescale 1ns / 1ps

module tlac_cfg_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [7:0]            cfg_data,
	output tlac_pkg::colour_set_t colours
);
	import tlac_pkg::*;

	colour_set_t colours_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colours_q.led0_red   <= RESET_RED;
			colours_q.led0_green <= RESET_GREEN;
			colours_q.led0_blue  <= RESET_BLUE;
			colours_q.led1_red   <= RESET_RED;
			colours_q.led1_green <= RESET_GREEN;
			colours_q.led1_blue  <= RESET_BLUE;
		end else if (cfg_we) begin
			// Indexes past the last register are dropped.
			case (cfg_index)
				REG_LED0_RED:   colours_q.led0_red   <= cfg_data;
				REG_LED0_GREEN: colours_q.led0_green <= cfg_data;
				REG_LED0_BLUE:  colours_q.led0_blue  <= cfg_data;
				REG_LED1_RED:   colours_q.led1_red   <= cfg_data;
				REG_LED1_GREEN: colours_q.led1_green <= cfg_data;
				REG_LED1_BLUE:  colours_q.led1_blue  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign colours = colours_q;

endmodule

/* sv/tlac_frame_logic.sv */
// Per-tick animation state and the result logic for one frame tick.
`timescale 1ns / 1ps

module tlac_frame_logic (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [15:0]            frame_number,
	input  logic                   key0_level,
	input  logic                   key1_level,
	input  logic                   mode_key_level,
	input  tlac_pkg::colour_set_t  colours,
	output tlac_pkg::result_t      result,
	output tlac_pkg::frame_state_t state
);
	import tlac_pkg::*;

	frame_state_t state_q;
	frame_state_t state_d;
	logic         k0_pressed;
	logic         k1_pressed;
	logic         km_pressed;
	logic [8:0]   dec0;
	logic [8:0]   dec1;
	logic [4:0]   bright0;
	logic [4:0]   bright1;
	logic         lit;
	key_event_t   ev0;
	key_event_t   ev1;

	assign k0_pressed = ~key0_level;
	assign k1_pressed = ~key1_level;
	assign km_pressed = ~mode_key_level;
	assign dec0 = (state_q.decay0 != 9'd0) ? state_q.decay0 - 9'd1 : 9'd0;
	assign dec1 = (state_q.decay1 != 9'd0) ? state_q.decay1 - 9'd1 : 9'd0;

	always_comb begin
		state_d = state_q;
		bright0 = 5'd0;
		bright1 = 5'd0;
		lit     = 1'b1;
		ev0     = EV_NONE;
		ev1     = EV_NONE;

		case (state_q.mode)
			MODE_OFF: begin
				lit = 1'b0;
			end
			MODE_STEADY: begin
				bright0 = STEADY_LEVEL;
				bright1 = STEADY_LEVEL;
			end
			MODE_BREATH: begin
				bright0 = WAVE[frame_number[10:3]][7:3];
				bright1 = bright0;
			end
			MODE_TAIL: begin
				// The counters step down before they index the tail.
				state_d.decay0 = dec0;
				state_d.decay1 = dec1;
				bright0 = WAVE[tail_index(dec0)][7:3];
				bright1 = WAVE[tail_index(dec1)][7:3];
			end
			default: begin
				lit = 1'b0;
			end
		endcase

		if (k0_pressed != state_q.k0_was) begin
			state_d.k0_was = k0_pressed;
			if (k0_pressed) begin
				ev0 = EV_DOWN;
				state_d.decay0 = DECAY_LOAD;
			end else begin
				ev0 = EV_UP;
			end
		end

		if (k1_pressed != state_q.k1_was) begin
			state_d.k1_was = k1_pressed;
			if (k1_pressed) begin
				ev1 = EV_DOWN;
				state_d.decay1 = DECAY_LOAD;
			end else begin
				ev1 = EV_UP;
			end
		end

		// A mode-key press advances the mode and blanks this tick.
		if (km_pressed != state_q.km_was) begin
			state_d.km_was = km_pressed;
			if (km_pressed) begin
				state_d.mode = anim_mode_t'(state_q.mode + 2'd1);
				lit = 1'b0;
			end
		end

		result.led0_brightness = lit ? bright0 : 5'd0;
		result.led1_brightness = lit ? bright1 : 5'd0;
		result.led0_red        = lit ? colours.led0_red   : 8'd0;
		result.led0_green      = lit ? colours.led0_green : 8'd0;
		result.led0_blue       = lit ? colours.led0_blue  : 8'd0;
		result.led1_red        = lit ? colours.led1_red   : 8'd0;
		result.led1_green      = lit ? colours.led1_green : 8'd0;
		result.led1_blue       = lit ? colours.led1_blue  : 8'd0;
		result.key0_event      = ev0;
		result.key1_event      = ev1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode   <= MODE_STEADY;
			state_q.decay0 <= 9'd0;
			state_q.decay1 <= 9'd0;
			state_q.k0_was <= 1'b0;
			state_q.k1_was <= 1'b0;
			state_q.km_was <= 1'b0;
		end else if (accept) begin
			state_q <= state_d;
		end
	end

	assign state = state_q;

endmodule

/* sv/tlac_out_stage.sv */
// Result register that holds one finished item until it is taken.
`timescale 1ns / 1ps

module tlac_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  tlac_pkg::result_t d,
	input  logic              out_ready,
	output logic              out_valid,
	output tlac_pkg::result_t q
);
	import tlac_pkg::*;

	logic    valid_q;
	result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

	assign out_valid = valid_q;
	assign q         = data_q;

endmodule
